// ===== rtl/core/pcm_pkg.sv =====
// shared constants and types of the polynomial color model evaluator
`default_nettype none
package pcm_pkg;
	localparam int MAX_CHANNELS = 4;
	localparam int DEG_LIMIT    = 5;
	localparam int TERM_DEPTH   = 128;

	localparam int CHAN_W  = $clog2(MAX_CHANNELS);
	localparam int LVL_W   = $clog2(DEG_LIMIT + 1);
	localparam int TERM_W  = $clog2(TERM_DEPTH);
	localparam int X_W     = 18;
	localparam int B_W     = 25;
	localparam int COEF_W  = 32;
	localparam int ACC_W   = COEF_W + X_W + TERM_W + 1;
	localparam int CFG_W   = 3;

	localparam logic signed [X_W-1:0] ONE_Q16 = 18'sd65536;
	localparam logic signed [X_W-1:0] X_MAX   = 18'sd131071;
	localparam logic signed [X_W-1:0] X_MIN   = -18'sd131072;

	localparam logic [1:0] CMD_EVAL  = 2'd0;
	localparam logic [1:0] CMD_COEFF = 2'd1;
	localparam logic [1:0] CMD_CHAN  = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	localparam logic [0:0] REG_CHANNEL_COUNT = 1'b0;
	localparam logic [0:0] REG_POLY_DEGREE   = 1'b1;

	typedef struct packed {
		logic clear;
		logic accumulate;
	} mac_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/pcm_mul.sv =====
// shared rounding multiplier with q2.16 saturation
`default_nettype none
module pcm_mul (
	input  logic signed [pcm_pkg::X_W-1:0] a,
	input  logic signed [pcm_pkg::B_W-1:0] b,
	input  logic                           frac16,
	output logic signed [pcm_pkg::X_W-1:0] y
);
	localparam int P_W = pcm_pkg::X_W + pcm_pkg::B_W;

	logic signed [P_W-1:0] prod;
	logic signed [P_W:0]   rnd;
	logic signed [P_W:0]   sh;

	always_comb begin
		prod = a * b;
		if (frac16) begin
			rnd = (P_W+1)'(prod) + (P_W+1)'(32768);
			sh  = rnd >>> 16;
		end else begin
			rnd = (P_W+1)'(prod) + (P_W+1)'(128);
			sh  = rnd >>> 8;
		end
		if (sh > (P_W+1)'(pcm_pkg::X_MAX))
			y = pcm_pkg::X_MAX;
		else if (sh < (P_W+1)'(pcm_pkg::X_MIN))
			y = pcm_pkg::X_MIN;
		else
			y = sh[pcm_pkg::X_W-1:0];
	end
endmodule
`default_nettype wire

// ===== rtl/core/pcm_coeff_mem.sv =====
// coefficient store, one bank per lab component, common read address
`default_nettype none
module pcm_coeff_mem (
	input  logic                             clk,
	input  logic                             we,
	input  logic [1:0]                       wr_comp,
	input  logic [pcm_pkg::TERM_W-1:0]       wr_addr,
	input  logic [pcm_pkg::COEF_W-1:0]       wr_data,
	input  logic [pcm_pkg::TERM_W-1:0]       rd_addr,
	output logic [3*pcm_pkg::COEF_W-1:0]     rd_data
);
	logic [pcm_pkg::COEF_W-1:0] bank_l [pcm_pkg::TERM_DEPTH];
	logic [pcm_pkg::COEF_W-1:0] bank_a [pcm_pkg::TERM_DEPTH];
	logic [pcm_pkg::COEF_W-1:0] bank_b [pcm_pkg::TERM_DEPTH];

	always_ff @(posedge clk) begin
		if (we && wr_comp == 2'd0) bank_l[wr_addr] <= wr_data;
		if (we && wr_comp == 2'd1) bank_a[wr_addr] <= wr_data;
		if (we && wr_comp == 2'd2) bank_b[wr_addr] <= wr_data;
		rd_data <= {bank_b[rd_addr], bank_a[rd_addr], bank_l[rd_addr]};
	end
endmodule
`default_nettype wire

// ===== rtl/core/pcm_mac.sv =====
// three-lane multiply-accumulate with final rounding and 32-bit saturation
`default_nettype none
module pcm_mac (
	input  logic                              clk,
	input  pcm_pkg::mac_ctl_t                 ctl,
	input  logic [3*pcm_pkg::COEF_W-1:0]      coeff,
	input  logic signed [pcm_pkg::X_W-1:0]    mono,
	output logic [3*pcm_pkg::COEF_W-1:0]      lab
);
	localparam int AW = pcm_pkg::ACC_W;
	localparam int RW = AW - 16;
	localparam int PW = pcm_pkg::COEF_W + pcm_pkg::X_W;

	logic signed [AW-1:0] acc_q [3];
	logic signed [PW-1:0] prod [3];

	// full-width product per lane
	always_comb begin
		for (int k = 0; k < 3; k++)
			prod[k] = $signed(coeff[k*pcm_pkg::COEF_W +: pcm_pkg::COEF_W]) * PW'(mono);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (ctl.clear)
				acc_q[k] <= '0;
			else if (ctl.accumulate)
				acc_q[k] <= acc_q[k] + AW'(prod[k]);
		end
	end

	always_comb begin
		logic signed [AW-1:0] r;
		logic signed [RW-1:0] s;
		for (int k = 0; k < 3; k++) begin
			r = acc_q[k] + AW'(32768);
			s = RW'(r >>> 16);
			if (s > RW'(64'sd2147483647))
				lab[k*32 +: 32] = 32'h7fffffff;
			else if (s < -RW'(64'sd2147483648))
				lab[k*32 +: 32] = 32'h80000000;
			else
				lab[k*32 +: 32] = s[31:0];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/polynomial_colour_model_eval.sv =====
// top level: command decode, normalisation and depth-first monomial walk
//
// channel   dir  width  contents
// s_axis    in   152    command beat: values, index, component, coefficient, channel params
// m_axis    out  96     one lab result per evaluate beat
// cfg       in   3      channel_count, polynomial_degree
//
// write beats give no result
// an evaluate beat walks C channel normalisations on the shared multiplier, then
// a coefficient read and a mac step per monomial term, T at most 126 at four
// channels and degree five; its result beat is offered after the walk, and the next
// input beat can be taken in the cycle after the result beat is taken
// reset clears the sequencer and presets cfg; other registers hold garbage until written
// s_tready stays low from an evaluate beat until its result beat is taken
`default_nettype none
module polynomial_colour_model_eval (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// value_0[15:0] value_1[31:16] value_2[47:32] value_3[63:48] entry_index[70:64]
	// lab_component[72:71] coeff_value[104:73] chan_offset[120:105] chan_scale[144:121]
	input  logic [151:0] s_tdata,
	// command[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// lab_l[31:0] lab_a[63:32] lab_b[95:64]
	output logic [95:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [2:0]   cfg_data
);
	localparam int XW = pcm_pkg::X_W;
	localparam int LW = pcm_pkg::LVL_W;
	localparam int CW = pcm_pkg::CHAN_W;
	localparam int TW = pcm_pkg::TERM_W;

	typedef enum logic [2:0] {ST_IDLE, ST_NORM, ST_READ, ST_MAC, ST_FIN, ST_OUT} state_t;

	state_t state_q;
	logic [2:0] chan_cfg_q, deg_cfg_q;
	logic [2:0] chans_q, deg_q;
	logic [CW-1:0] ncnt_q;
	logic [LW-1:0] depth_q;
	logic [TW-1:0] term_q;
	logic done_q;

	// payload
	logic [15:0] val_q [pcm_pkg::MAX_CHANNELS];
	logic [15:0] off_q [pcm_pkg::MAX_CHANNELS];
	logic [23:0] scl_q [pcm_pkg::MAX_CHANNELS];
	logic signed [XW-1:0] x_q [pcm_pkg::MAX_CHANNELS];
	logic signed [XW-1:0] mono_q [pcm_pkg::DEG_LIMIT+1];
	logic [CW-1:0] idx_q [pcm_pkg::DEG_LIMIT+1];
	logic signed [XW-1:0] cur_mono_s1;

	wire accept = s_tvalid && s_tready;
	wire [1:0] cmd = s_tuser;
	wire [6:0] entry_index = s_tdata[70:64];
	wire [1:0] lab_component = s_tdata[72:71];

	// register clamping
	logic [2:0] chans_use, deg_use;
	always_comb begin
		chans_use = chan_cfg_q;
		if (chan_cfg_q == 3'd0) chans_use = 3'd1;
		else if (chan_cfg_q > 3'(pcm_pkg::MAX_CHANNELS)) chans_use = 3'(pcm_pkg::MAX_CHANNELS);
		deg_use = deg_cfg_q;
		if (deg_cfg_q == 3'd0) deg_use = 3'd1;
		else if (deg_cfg_q > 3'(pcm_pkg::DEG_LIMIT)) deg_use = 3'(pcm_pkg::DEG_LIMIT);
	end

	// next node of the walk: child while below the degree, else the deepest
	// level whose index can still step up
	logic child, found;
	logic [LW-1:0] sib_lvl, new_lvl, src_lvl;
	logic [CW-1:0] new_idx;
	always_comb begin
		child = {1'b0, depth_q} < {1'b0, deg_q};
		found = 1'b0;
		sib_lvl = '0;
		for (int e = 1; e <= pcm_pkg::DEG_LIMIT; e++) begin
			if (LW'(e) <= depth_q && ({1'b0, idx_q[e]} + 3'd1) < chans_q) begin
				found = 1'b1;
				sib_lvl = LW'(e);
			end
		end
		new_lvl = child ? depth_q + LW'(1) : sib_lvl;
		src_lvl = child ? depth_q : sib_lvl - LW'(1);
		new_idx = child ? idx_q[depth_q] : idx_q[sib_lvl] + CW'(1);
	end

	// shared multiplier operand select
	logic signed [XW-1:0] mul_a, mul_y;
	logic signed [pcm_pkg::B_W-1:0] mul_b;
	logic mul_frac16;
	always_comb begin
		if (state_q == ST_NORM) begin
			mul_a = XW'($signed({2'b00, val_q[ncnt_q]}) - $signed({2'b00, off_q[ncnt_q]}));
			mul_b = $signed({1'b0, scl_q[ncnt_q]});
			mul_frac16 = 1'b0;
		end else begin
			mul_a = mono_q[src_lvl];
			mul_b = pcm_pkg::B_W'(x_q[new_idx]);
			mul_frac16 = 1'b1;
		end
	end

	pcm_mul u_mul (.a(mul_a), .b(mul_b), .frac16(mul_frac16), .y(mul_y));

	logic [3*pcm_pkg::COEF_W-1:0] coeff_rd;
	pcm_coeff_mem u_coeff (
		.clk(clk),
		.we(accept && cmd == pcm_pkg::CMD_COEFF && lab_component != 2'd3),
		.wr_comp(lab_component),
		.wr_addr(entry_index[TW-1:0]),
		.wr_data(s_tdata[104:73]),
		.rd_addr(term_q),
		.rd_data(coeff_rd)
	);

	pcm_pkg::mac_ctl_t mac_ctl;
	logic [95:0] lab_rnd;
	wire last_norm = ({1'b0, ncnt_q} + 3'd1) == chans_q;
	always_comb begin
		mac_ctl.clear = (state_q == ST_NORM) && last_norm;
		mac_ctl.accumulate = (state_q == ST_MAC);
	end

	pcm_mac u_mac (.clk(clk), .ctl(mac_ctl), .coeff(coeff_rd), .mono(cur_mono_s1), .lab(lab_rnd));

	assign s_tready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			chan_cfg_q <= 3'd4;
			deg_cfg_q <= 3'd2;
			chans_q <= 3'd1;
			deg_q <= 3'd1;
			ncnt_q <= '0;
			depth_q <= '0;
			term_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pcm_pkg::REG_CHANNEL_COUNT: chan_cfg_q <= cfg_data;
					pcm_pkg::REG_POLY_DEGREE:   deg_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cmd == pcm_pkg::CMD_EVAL) begin
						chans_q <= chans_use;
						deg_q <= deg_use;
						ncnt_q <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					ncnt_q <= ncnt_q + CW'(1);
					if (last_norm) begin
						depth_q <= '0;
						term_q <= '0;
						done_q <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (child || found)
						depth_q <= new_lvl;
					done_q <= !(child || found);
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					term_q <= term_q + TW'(1);
					if (done_q || term_q == TW'(pcm_pkg::TERM_DEPTH - 1))
						state_q <= ST_FIN;
					else
						state_q <= ST_READ;
				end
				ST_FIN: begin
					m_tvalid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && cmd == pcm_pkg::CMD_EVAL) begin
			for (int i = 0; i < pcm_pkg::MAX_CHANNELS; i++)
				val_q[i] <= s_tdata[16*i +: 16];
		end
		if (accept && cmd == pcm_pkg::CMD_CHAN && entry_index < 7'(pcm_pkg::MAX_CHANNELS)) begin
			off_q[entry_index[CW-1:0]] <= s_tdata[120:105];
			scl_q[entry_index[CW-1:0]] <= s_tdata[144:121];
		end
		if (state_q == ST_NORM) begin
			x_q[ncnt_q] <= mul_y;
			mono_q[0] <= pcm_pkg::ONE_Q16;
			idx_q[0] <= '0;
		end
		if (state_q == ST_READ) begin
			cur_mono_s1 <= mono_q[depth_q];
			if (child || found) begin
				mono_q[new_lvl] <= mul_y;
				idx_q[new_lvl] <= new_idx;
			end
		end
		if (state_q == ST_FIN)
			m_tdata <= lab_rnd;
	end

	// walk never goes deeper than the latched degree
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_MAC) |-> depth_q <= deg_q)
		else $error("walk depth above degree");
	// a result appears only after the final mac step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_FIN))
		else $error("result without finished walk");
	// input side stays closed while a result waits
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input open during pending result");
	// mac step always follows a coefficient read
	a_mac_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_MAC)
		else $error("mac without read");
endmodule
`default_nettype wire
